@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL.
// No dependencies; compiled away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

@@ rtl/core/sha256d_pkg.sv @@
// Package for the double SHA-256 nonce hasher: constants, types and round functions.
// No dependencies.
package sha256d_pkg;

    localparam int NumRounds = 64;
    localparam int CfgAddrW  = 6;

    typedef logic [31:0] t_word;
    typedef t_word t_state [8];

    typedef enum logic [2:0] {
        REG_MID01  = 3'd0,
        REG_MID23  = 3'd1,
        REG_MID45  = 3'd2,
        REG_MID67  = 3'd3,
        REG_TAIL01 = 3'd4,
        REG_TAIL2  = 3'd5,
        REG_NONE6  = 3'd6,
        REG_NONE7  = 3'd7
    } t_reg_idx;

    localparam t_word InitH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word rotr(input t_word x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word sig0(input t_word x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word sig1(input t_word x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // One compression round on state v with round key plus schedule word kw.
    function automatic t_state round_fn(input t_state v, input t_word kw);
        t_word  t1;
        t_word  t2;
        t_state r;
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kw;
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        r[7] = v[6]; r[6] = v[5]; r[5] = v[4]; r[4] = v[3] + t1;
        r[3] = v[2]; r[2] = v[1]; r[1] = v[0]; r[0] = t1 + t2;
        round_fn = r;
    endfunction

endpackage

@@ rtl/core/sha256d_compress.sv @@
// One fully unrolled SHA-256 compression: one register stage per round.
// Depends on sha256d_pkg.
module sha256d_compress import sha256d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_word       i_chain [8],
    input  t_word       i_msg [16],
    input  logic [31:0] i_tag,
    output logic        o_valid,
    output t_word       o_chain [8],
    output logic [31:0] o_tag
);

    // Per stage: working state, sliding 16-word schedule window, chain, tag.
    logic        r_vld   [1:NumRounds];
    t_state      r_v     [1:NumRounds];
    t_word       r_w     [1:NumRounds][16];
    t_state      r_chain [1:NumRounds];
    logic [31:0] r_tag   [1:NumRounds];

    for (genvar g = 0; g < NumRounds; g++) begin : g_round
        logic        s_vld;
        t_state      s_v;
        t_word       s_w [16];
        t_state      s_chain;
        logic [31:0] s_tag;
        t_word       n_new;

        // Stage source: the ports for the first round, the previous stage after.
        if (g == 0) begin : g_src
            assign s_vld   = i_valid;
            assign s_v     = i_chain;
            assign s_w     = i_msg;
            assign s_chain = i_chain;
            assign s_tag   = i_tag;
        end else begin : g_src
            assign s_vld   = r_vld[g];
            assign s_v     = r_v[g];
            assign s_w     = r_w[g];
            assign s_chain = r_chain[g];
            assign s_tag   = r_tag[g];
        end

        assign n_new = sig1(s_w[14]) + s_w[9] + sig0(s_w[1]) + s_w[0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_v[g+1]     <= round_fn(s_v, RoundK[g] + s_w[0]);
            r_chain[g+1] <= s_chain;
            r_tag[g+1]   <= s_tag;
            for (int j = 0; j < 15; j++) begin
                r_w[g+1][j] <= s_w[j+1];
            end
            r_w[g+1][15] <= n_new;
        end
    end

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            o_chain[j] = r_chain[NumRounds][j] + r_v[NumRounds][j];
        end
    end
    assign o_valid = r_vld[NumRounds];
    assign o_tag   = r_tag[NumRounds];

endmodule

@@ rtl/core/sha256d_nonce_zero_count.sv @@
// Top level of the double SHA-256 nonce hasher with register port.
// Depends on sha256d_pkg, sha256d_compress and assert_macros.svh.
//
// Usage: write the midstate of header bytes 0..63 and header bytes 64..75
// over the APB port (64-bit registers at byte addresses 8*i), then issue
// nonces: a word is taken at each rising edge with start high; busy is
// always low, so one nonce enters every cycle.
// Each nonce runs through two unrolled compressions of 64 round stages,
// then one output register stage that also counts trailing zero bits of
// the digest (last byte first, MSB first in each byte).
// o_done rises once the nonce has passed both compressions and the output
// register; throughput one word per cycle, set by the one-round-per-stage pipe.
// o_done marks each result for exactly one cycle; the receiver cannot stall
// and none is needed since nothing ever waits in the pipe.
// Reset clears every stage valid bit and the configuration registers.
// Registers must be written only while no nonce is in flight.
`include "assert_macros.svh"
module sha256d_nonce_zero_count import sha256d_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CfgAddrW-1:0] paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    input  logic                start,
    output logic                busy,
    input  logic [31:0]         i_nonce,
    output logic                o_done,
    output logic [31:0]         o_nonce_echo,
    output logic [8:0]          o_zero_count,
    output logic [63:0]         o_digest_part0,
    output logic [63:0]         o_digest_part1,
    output logic [63:0]         o_digest_part2,
    output logic [63:0]         o_digest_part3
);

    logic [63:0] r_mid [4];
    logic [63:0] r_tail01;
    logic [31:0] r_tail2;
    t_reg_idx    reg_idx;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_wr  = psel && penable && pwrite;
    // Decode 8-byte register slots; drop the byte offset bits.
    always_comb begin
        reg_idx = t_reg_idx'(paddr[5:3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid    <= '{default: '0};
            r_tail01 <= '0;
            r_tail2  <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_MID01:  r_mid[0] <= pwdata;
                REG_MID23:  r_mid[1] <= pwdata;
                REG_MID45:  r_mid[2] <= pwdata;
                REG_MID67:  r_mid[3] <= pwdata;
                REG_TAIL01: r_tail01 <= pwdata;
                REG_TAIL2:  r_tail2  <= pwdata[31:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MID01:  prdata = r_mid[0];
            REG_MID23:  prdata = r_mid[1];
            REG_MID45:  prdata = r_mid[2];
            REG_MID67:  prdata = r_mid[3];
            REG_TAIL01: prdata = r_tail01;
            REG_TAIL2:  prdata = {32'd0, r_tail2};
            default:    prdata = '0;
        endcase
    end

    // First hash, second block: tail words, byte-swapped nonce, padding.
    t_word chain_a [8];
    t_word msg_a [16];
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            chain_a[2*j]   = r_mid[j][63:32];
            chain_a[2*j+1] = r_mid[j][31:0];
        end
        msg_a     = '{default: '0};
        msg_a[0]  = r_tail01[63:32];
        msg_a[1]  = r_tail01[31:0];
        msg_a[2]  = r_tail2;
        msg_a[3]  = {i_nonce[7:0], i_nonce[15:8], i_nonce[23:16], i_nonce[31:24]};
        msg_a[4]  = 32'h80000000;
        msg_a[15] = 32'd640;
    end

    logic        vld_a;
    t_word       dig_a [8];
    logic [31:0] tag_a;

    sha256d_compress u_hash1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_chain (chain_a),
        .i_msg   (msg_a),
        .i_tag   (i_nonce),
        .o_valid (vld_a),
        .o_chain (dig_a),
        .o_tag   (tag_a)
    );

    // Second hash: 32-byte digest plus padding from the initial value.
    t_word msg_b [16];
    always_comb begin
        msg_b = '{default: '0};
        for (int j = 0; j < 8; j++) begin
            msg_b[j] = dig_a[j];
        end
        msg_b[8]  = 32'h80000000;
        msg_b[15] = 32'd256;
    end

    logic        vld_b;
    t_word       dig_b [8];
    logic [31:0] tag_b;

    sha256d_compress u_hash2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (vld_a),
        .i_chain (InitH),
        .i_msg   (msg_b),
        .i_tag   (tag_a),
        .o_valid (vld_b),
        .o_chain (dig_b),
        .o_tag   (tag_b)
    );

    // Count zero bits from the last byte backward: walk the flat 256-bit digest
    // from its lowest byte up, MSB first in each byte, until the first set bit.
    logic [255:0] flat;
    logic [8:0]   n_count;
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            flat[255-32*j -: 32] = dig_b[j];
        end
        n_count = 9'd256;
        for (int b = 0; b < 32; b++) begin
            for (int k = 7; k >= 0; k--) begin
                if (flat[8*b+k] && n_count == 9'd256) begin
                    n_count = 9'(8*b + 7 - k);
                end
            end
        end
    end

    logic r_done;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= vld_b;
        end
    end

    always_ff @(posedge i_clk) begin
        o_nonce_echo   <= tag_b;
        o_zero_count   <= n_count;
        o_digest_part0 <= {dig_b[0], dig_b[1]};
        o_digest_part1 <= {dig_b[2], dig_b[3]};
        o_digest_part2 <= {dig_b[4], dig_b[5]};
        o_digest_part3 <= {dig_b[6], dig_b[7]};
    end
    assign o_done = r_done;

    `ASSERT_IMPLIES(a_never_busy, i_clk, i_rst_n, 1'b1, !busy)
    `ASSERT_NEXT(a_done_follows, i_clk, i_rst_n, vld_b, o_done)
    `ASSERT_IMPLIES(a_count_range, i_clk, i_rst_n, o_done, o_zero_count <= 9'd256)

endmodule

@@ sim/sha256d_nonce_zero_count_chk.sv @@
// Scoreboard for the double SHA-256 nonce hasher: mirrors the APB registers,
// predicts each digest and zero count, and compares against o_done results.
// Depends on sha256d_pkg for the register enum and the SHA-256 constants.
module sha256d_nonce_zero_count_chk import sha256d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] i_nonce,
    input  logic        o_done,
    input  logic [31:0] o_nonce_echo,
    input  logic [8:0]  o_zero_count,
    input  logic [63:0] o_digest_part0,
    input  logic [63:0] o_digest_part1,
    input  logic [63:0] o_digest_part2,
    input  logic [63:0] o_digest_part3,
    output int          o_err_cnt,
    output int          o_pending
);

    typedef struct packed {
        logic [31:0]  nonce;
        logic [8:0]   zeros;
        logic [255:0] digest;
    } t_hash_res;

    logic [63:0] mid_q [4];
    logic [63:0] tail01_q;
    logic [31:0] tail2_q;
    t_hash_res   hash_q [$];

    assign o_pending = hash_q.size();

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Run one compression over blk, adding into chain in place.
    function automatic void sha_block(inout logic [31:0] chain [8],
                                      input logic [31:0] blk [16]);
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int i = 0; i < 16; i++) w[i] = blk[i];
        for (int i = 16; i < 64; i++) begin
            w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        end
        for (int i = 0; i < 8; i++) v[i] = chain[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain[i] += v[i];
    endfunction

    function automatic t_hash_res hash_nonce(input logic [31:0] nonce);
        logic [31:0] chain [8];
        logic [31:0] blk [16];
        logic [7:0]  b;
        t_hash_res   r;
        int          cnt;
        bit          hit;
        for (int i = 0; i < 4; i++) begin
            chain[2*i]   = mid_q[i][63:32];
            chain[2*i+1] = mid_q[i][31:0];
        end
        // Finish the header: bytes 64..79, pad bit, 640-bit length.
        for (int i = 0; i < 16; i++) blk[i] = '0;
        blk[0]  = tail01_q[63:32];
        blk[1]  = tail01_q[31:0];
        blk[2]  = tail2_q;
        blk[3]  = {nonce[7:0], nonce[15:8], nonce[23:16], nonce[31:24]};
        blk[4]  = 32'h8000_0000;
        blk[15] = 32'd640;
        sha_block(chain, blk);
        // Rehash the 32-byte digest from the standard IV.
        for (int i = 0; i < 8; i++) blk[i] = chain[i];
        for (int i = 8; i < 16; i++) blk[i] = '0;
        blk[8]  = 32'h8000_0000;
        blk[15] = 32'd256;
        for (int i = 0; i < 8; i++) chain[i] = InitH[i];
        sha_block(chain, blk);
        cnt = 0;
        hit = 0;
        for (int i = 31; i >= 0 && !hit; i--) begin
            b = 8'(chain[i/4] >> (8 * (3 - (i % 4))));
            for (int j = 7; j >= 0 && !hit; j--) begin
                if (b[j]) hit = 1;
                else cnt++;
            end
        end
        r.nonce = nonce;
        r.zeros = 9'(cnt);
        for (int i = 0; i < 8; i++) r.digest[255 - 32*i -: 32] = chain[i];
        return r;
    endfunction

    task automatic report_err(input string what, input logic [255:0] got,
                              input logic [255:0] want);
        $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
        o_err_cnt++;
    endtask

    initial o_err_cnt = 0;

    always @(posedge i_clk) begin
        t_hash_res exp_r;
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) mid_q[i] = '0;
            tail01_q = '0;
            tail2_q  = '0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[5:3]))
                    REG_MID01:  mid_q[0] = pwdata;
                    REG_MID23:  mid_q[1] = pwdata;
                    REG_MID45:  mid_q[2] = pwdata;
                    REG_MID67:  mid_q[3] = pwdata;
                    REG_TAIL01: tail01_q = pwdata;
                    REG_TAIL2:  tail2_q  = pwdata[31:0];
                    default: ;
                endcase
            end
            if (start && !busy) hash_q.push_back(hash_nonce(i_nonce));
            if (o_done) begin
                if (hash_q.size() == 0) begin
                    report_err("unexpected word", 256'(o_nonce_echo), '0);
                end else begin
                    exp_r = hash_q.pop_front();
                    if (o_nonce_echo !== exp_r.nonce)
                        report_err("nonce_echo", 256'(o_nonce_echo), 256'(exp_r.nonce));
                    if (o_zero_count !== exp_r.zeros)
                        report_err("zero_count", 256'(o_zero_count), 256'(exp_r.zeros));
                    if (o_digest_part0 !== exp_r.digest[255:192])
                        report_err("digest_part0", 256'(o_digest_part0),
                                   256'(exp_r.digest[255:192]));
                    if (o_digest_part1 !== exp_r.digest[191:128])
                        report_err("digest_part1", 256'(o_digest_part1),
                                   256'(exp_r.digest[191:128]));
                    if (o_digest_part2 !== exp_r.digest[127:64])
                        report_err("digest_part2", 256'(o_digest_part2),
                                   256'(exp_r.digest[127:64]));
                    if (o_digest_part3 !== exp_r.digest[63:0])
                        report_err("digest_part3", 256'(o_digest_part3),
                                   256'(exp_r.digest[63:0]));
                end
            end
        end
    end

endmodule

@@ sim/sha256d_nonce_zero_count_tb.sv @@
// Testbench top for the double SHA-256 nonce hasher: drives APB register
// writes and nonce words, and gives the verdict from the scoreboard count.
// Depends on sha256d_pkg, sha256d_nonce_zero_count and sha256d_nonce_zero_count_chk.
module sha256d_nonce_zero_count_tb;
    import sha256d_pkg::*;

    localparam int PipeLat  = 130;
    localparam int CycLimit = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic [31:0] i_nonce;
    logic        o_done;
    logic [31:0] o_nonce_echo;
    logic [8:0]  o_zero_count;
    logic [63:0] o_digest_part0;
    logic [63:0] o_digest_part1;
    logic [63:0] o_digest_part2;
    logic [63:0] o_digest_part3;
    int          err_cnt;
    int          pending;
    int          cyc_cnt;

    sha256d_nonce_zero_count i_dut (.*);

    sha256d_nonce_zero_count_chk i_chk (
        .o_err_cnt (err_cnt),
        .o_pending (pending),
        .*
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: end the run if the pipe hangs or stimulus stalls forever.
    initial cyc_cnt = 0;
    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt > CycLimit) begin
            $display("sha256d_nonce_zero_count_tb failed");
            $finish;
        end
    end

    // Two-phase APB write; hold start low meanwhile.
    task automatic reg_write(input t_reg_idx idx, input logic [63:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Drain the pipe before touching registers.
    task automatic wait_drain();
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Load a full midstate/tail setting; mode 0 zeros, 1 ones, else random.
    task automatic load_header(input int mode);
        logic [63:0] v;
        for (int i = REG_MID01; i <= REG_TAIL2; i++) begin
            v = (mode == 0) ? '0 : (mode == 1) ? '1 : {$urandom, $urandom};
            reg_write(t_reg_idx'(i), v);
        end
        // Hit the unmapped slots too; these must leave the header alone.
        reg_write(REG_NONE6, {$urandom, $urandom});
        reg_write(REG_NONE7, '1);
    endtask

    // Issue one nonce word, inserting idle cycles at idle_pct percent.
    task automatic send_nonce(input logic [31:0] n, input int idle_pct);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start   = 1'b1;
        i_nonce = n;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drop_start();
        @(negedge i_clk);
        start = 1'b0;
    endtask

    initial begin
        int idle_pct;
        int settle;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        start   = 1'b0;
        i_nonce = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset header, nonce extremes and walking patterns.
        send_nonce(32'h0000_0000, 0);
        send_nonce(32'hffff_ffff, 0);
        send_nonce(32'h0000_0001, 0);
        send_nonce(32'h8000_0000, 0);
        send_nonce(32'h5555_5555, 0);
        send_nonce(32'haaaa_aaaa, 0);
        send_nonce(32'h00ff_00ff, 0);
        send_nonce(32'h1234_5678, 0);
        for (int i = 0; i < 8; i++) send_nonce(32'h1 << (4 * i + 3), 0);
        drop_start();
        wait_drain();
        load_header(1);
        send_nonce(32'h0000_0000, 0);
        send_nonce(32'hffff_ffff, 0);
        send_nonce(32'hdead_beef, 0);
        drop_start();
        wait_drain();

        // Random: rotate idle rates and header settings, zeros included.
        for (int ph = 0; ph < 10; ph++) begin
            load_header(ph == 3 ? 0 : ph == 6 ? 1 : 2);
            case (ph % 3)
                0: idle_pct = 0;
                1: idle_pct = 57;
                default: idle_pct = 11;
            endcase
            for (int k = 0; k < 150; k++) send_nonce($urandom, idle_pct);
            drop_start();
            wait_drain();
        end

        // Let the pipe settle, then check nothing stray comes out.
        settle = 0;
        while (pending != 0 && settle < 10 * PipeLat) begin
            @(posedge i_clk);
            settle++;
        end
        repeat (PipeLat + 10) @(posedge i_clk);
        if (err_cnt == 0 && pending == 0) begin
            $display("sha256d_nonce_zero_count_tb passed");
        end else begin
            $display("sha256d_nonce_zero_count_tb failed");
        end
        $finish;
    end

endmodule

@@ sha256d_nonce_zero_count.f @@
+incdir+rtl/core
rtl/core/sha256d_pkg.sv
rtl/core/sha256d_compress.sv
rtl/core/sha256d_nonce_zero_count.sv
sim/sha256d_nonce_zero_count_chk.sv
sim/sha256d_nonce_zero_count_tb.sv
